@@ sv/gic_pkg.sv @@
`default_nettype none

package gic_pkg;

  // Field widths
  localparam int unsigned BTN_W    = 24;
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned AXIS_W   = 8;
  localparam int unsigned NUM_AXES = 6;
  localparam int unsigned DZ_W     = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;

  // Button bitmap layout
  localparam logic [BTN_W-1:0] BTN_DPAD  = 24'h00000F;
  localparam logic [BTN_W-1:0] BTN_S1S2  = 24'h003000;
  localparam logic [BTN_W-1:0] BTN_HOME  = 24'h010000;
  localparam int unsigned BTN_UP_BIT    = 0;
  localparam int unsigned BTN_DOWN_BIT  = 1;
  localparam int unsigned BTN_LEFT_BIT  = 2;
  localparam int unsigned BTN_RIGHT_BIT = 3;
  localparam int unsigned BTN_R3_BIT    = 15;

  localparam logic [3:0] COMBO_DOWN  = 4'b0010;
  localparam logic [3:0] COMBO_LEFT  = 4'b0100;
  localparam logic [3:0] COMBO_RIGHT = 4'b1000;

  // Hat direction bits
  localparam int unsigned HAT_UP_BIT    = 0;
  localparam int unsigned HAT_DOWN_BIT  = 1;
  localparam int unsigned HAT_LEFT_BIT  = 2;
  localparam int unsigned HAT_RIGHT_BIT = 3;

  // Converter range and scaling: q = ((s - ADC_LO) * 255) / (ADC_HI - ADC_LO),
  // done as a multiplication by a rounded-up reciprocal, exact for every
  // numerator below 2^19.
  localparam logic [SAMPLE_W-1:0] ADC_LO = 12'd1100;
  localparam logic [SAMPLE_W-1:0] ADC_HI = 12'd3000;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam logic [19:0] RECIP = 20'd565128;

  localparam logic [AXIS_W-1:0] AXIS_MIN    = 8'd0;
  localparam logic [AXIS_W-1:0] AXIS_CENTER = 8'd128;
  localparam logic [AXIS_W-1:0] AXIS_MAX    = 8'd255;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_INVERT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HAT_ENABLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE_A    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE_B    = 3'd5;

  // Toggle function codes
  localparam logic [1:0] TOG_NONE  = 2'd0;
  localparam logic [1:0] TOG_LEFT  = 2'd1;
  localparam logic [1:0] TOG_RIGHT = 2'd2;

  typedef enum logic [1:0] {
    MODE_BUTTONS = 2'd0,
    MODE_LEFT    = 2'd1,
    MODE_RIGHT   = 2'd2
  } mode_t;

  // S1+S2 combination tracking
  typedef struct packed {
    logic  was_held;
    logic  consumed;
    mode_t chosen;
  } combo_st_t;

  // Result of the button path
  typedef struct packed {
    logic [BTN_W-1:0] buttons;
    logic [3:0]       dpad;
    mode_t            mode;
  } btn_res_t;

endpackage

`default_nettype wire

@@ sv/gic_scale.sv @@
`default_nettype none

// One converter lane: clamp, scale to 0..255, optional invert and deadzone.
module gic_scale (
  input  wire logic [gic_pkg::SAMPLE_W-1:0] sample,
  input  wire logic                          invert,
  input  wire logic [gic_pkg::DZ_W-1:0]      deadzone,
  output logic      [gic_pkg::AXIS_W-1:0]    value
);
  import gic_pkg::*;

  logic [SAMPLE_W-1:0] clamped;
  logic [10:0]         offset;
  logic [18:0]         numer;
  logic [38:0]         product;
  logic [AXIS_W-1:0]   scaled;
  logic [AXIS_W-1:0]   oriented;
  logic [AXIS_W:0]     centred;
  logic [AXIS_W-1:0]   magnitude;

  always_comb begin
    if (sample < ADC_LO) begin
      clamped = ADC_LO;
    end else if (sample > ADC_HI) begin
      clamped = ADC_HI;
    end else begin
      clamped = sample;
    end
    offset  = 11'(clamped - ADC_LO);
    // offset * 255 as a shift and subtract
    numer   = {offset, 8'b0} - 19'(offset);
    product = 39'(numer) * 39'(RECIP);
    scaled  = product[RECIP_SHIFT +: AXIS_W];
    oriented = invert ? ~scaled : scaled;
    centred  = {1'b0, oriented} - {1'b0, AXIS_CENTER};
    magnitude = centred[AXIS_W] ? AXIS_W'(-centred) : centred[AXIS_W-1:0];
    value = (magnitude < {1'b0, deadzone}) ? AXIS_CENTER : oriented;
  end

endmodule

`default_nettype wire

@@ sv/gic_buttons.sv @@
`default_nettype none

// Button path: sample agreement, S1+S2 combination, toggle override and
// removal of the d-pad in stick modes.
module gic_buttons (
  input  wire logic [gic_pkg::BTN_W-1:0] raw,
  input  wire logic [gic_pkg::BTN_W-1:0] prev_raw,
  input  wire logic [gic_pkg::BTN_W-1:0] held,
  input  wire gic_pkg::combo_st_t        combo,
  input  wire logic [1:0]                levels,
  input  wire logic [1:0]                tog_a,
  input  wire logic [1:0]                tog_b,
  output gic_pkg::combo_st_t             combo_nxt,
  output gic_pkg::btn_res_t              res
);
  import gic_pkg::*;

  logic [BTN_W-1:0] agreed;
  logic [BTN_W-1:0] after_combo;
  logic [BTN_W-1:0] others;
  logic [3:0]       dpad_combo;
  logic             consumed;
  mode_t            chosen;
  mode_t            mode;

  always_comb begin
    agreed     = (raw == prev_raw) ? raw : held;
    dpad_combo = agreed[3:0];
    others     = agreed & ~(BTN_S1S2 | BTN_DPAD);
    consumed   = combo.consumed;
    chosen     = combo.chosen;
    after_combo = agreed;
    combo_nxt  = combo;

    if ((agreed & BTN_S1S2) == BTN_S1S2) begin
      // A fresh hold may choose a mode once, with exactly one direction.
      if (!combo.was_held) begin
        consumed = 1'b0;
      end
      if (!consumed) begin
        if (dpad_combo == COMBO_DOWN) begin
          chosen   = MODE_BUTTONS;
          consumed = 1'b1;
        end else if (dpad_combo == COMBO_LEFT) begin
          chosen   = MODE_LEFT;
          consumed = 1'b1;
        end else if (dpad_combo == COMBO_RIGHT) begin
          chosen   = MODE_RIGHT;
          consumed = 1'b1;
        end
      end
      after_combo = (!consumed && others == '0) ? BTN_HOME : '0;
      combo_nxt.was_held = 1'b1;
    end else begin
      combo_nxt.was_held = 1'b0;
    end
    combo_nxt.consumed = consumed;
    combo_nxt.chosen   = chosen;

    // Toggle b is applied after toggle a, so it wins.
    mode = chosen;
    if (levels[0] && (tog_a == TOG_LEFT || tog_a == TOG_RIGHT)) begin
      mode = mode_t'(tog_a);
    end
    if (levels[1] && (tog_b == TOG_LEFT || tog_b == TOG_RIGHT)) begin
      mode = mode_t'(tog_b);
    end

    res.dpad = after_combo[3:0];
    res.mode = mode;
    res.buttons = (mode != MODE_BUTTONS) ? (after_combo & ~BTN_DPAD) : after_combo;
  end

endmodule

`default_nettype wire

@@ sv/gamepad_input_conditioner.sv @@
`default_nettype none

// Gamepad input conditioner. Each request on the in_ channel is one poll of
// the controller: a raw button bitmap, two toggle switch levels, four right
// hat directions and six 12-bit converter samples. Each poll yields exactly
// one report on the out_ channel with the conditioned button bitmap, four
// stick axes (128 centre) and two triggers. A button bitmap is only taken
// when it matches the previous poll; otherwise the last reported bitmap is
// repeated. Holding S1+S2 picks the d-pad mode with Down, Left or Right
// (once per hold), injects Home alone, or blanks the buttons. Toggle
// switches can force a stick mode, in which the d-pad drives a stick to
// 0/128/255. Wired converter channels are clamped to 1100..3000, scaled to
// 0..255, optionally inverted and given a deadzone; an enabled hat drives
// the right stick and masks R3. The block takes one poll per clock cycle
// while the result register can advance: a poll sits in an input register
// while the button and axis logic runs, and its report is then captured in
// the result register. The result register doubles as the conditioner
// state, so it only advances when the report ahead has been taken or the
// result register is empty; a poll can still be accepted into the input
// register while a report waits. Configuration registers are
// written through the cfg_ port and should only be changed while the block
// is idle.
module gamepad_input_conditioner (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Configuration write port
  input  wire logic         cfg_wr_en,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [6:0]   cfg_wdata,
  // Poll input
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // raw_buttons[23:0], toggle_levels[25:24], hat_dirs[29:26], sample_lx[41:30],
  // sample_ly[53:42], sample_rx[65:54], sample_ry[77:66], sample_lt[89:78],
  // sample_rt[101:90], zero fill [103:102]
  input  wire logic [103:0] in_tdata,
  // Conditioned report
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // out_buttons[23:0], left_x[31:24], left_y[39:32], right_x[47:40],
  // right_y[55:48], left_trigger[63:56], right_trigger[71:64]
  output logic [71:0]       out_tdata
);
  import gic_pkg::*;

  // Configuration registers
  logic [DZ_W-1:0]     deadzone_r;
  logic [NUM_AXES-1:0] axis_enable_r;
  logic [3:0]          axis_invert_r;
  logic                hat_enable_r;
  logic [1:0]          tog_a_r;
  logic [1:0]          tog_b_r;

  // Input register
  logic                s1_valid_r;
  logic [BTN_W-1:0]    s1_raw_r;
  logic [1:0]          s1_levels_r;
  logic [3:0]          s1_hat_r;
  logic [SAMPLE_W-1:0] s1_sample_r [NUM_AXES];

  // Conditioner state; buttons and axes are also the result register
  logic                out_valid_r;
  logic [BTN_W-1:0]    prev_raw_r;
  logic [BTN_W-1:0]    held_r;
  combo_st_t           combo_r;
  mode_t               last_mode_r;
  logic [AXIS_W-1:0]   axis_r [NUM_AXES];

  logic                advance;
  logic                fire;
  combo_st_t           combo_nxt;
  btn_res_t            btn_res;
  logic [BTN_W-1:0]    held_nxt;
  logic [NUM_AXES-1:0] lane_invert;
  logic [AXIS_W-1:0]   scaled [NUM_AXES];
  logic [AXIS_W-1:0]   axis_nxt [NUM_AXES];
  logic [AXIS_W-1:0]   dpad_x;
  logic [AXIS_W-1:0]   dpad_y;

  // The result register moves on when it is empty or its report is taken.
  assign advance   = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  gic_buttons u_buttons (
    .raw       (s1_raw_r),
    .prev_raw  (prev_raw_r),
    .held      (held_r),
    .combo     (combo_r),
    .levels    (s1_levels_r),
    .tog_a     (tog_a_r),
    .tog_b     (tog_b_r),
    .combo_nxt (combo_nxt),
    .res       (btn_res)
  );

  // Only the four stick lanes have an invert bit.
  assign lane_invert = NUM_AXES'(axis_invert_r);

  // One scaling lane per converter channel; triggers get no invert or
  // deadzone.
  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    gic_scale u_scale (
      .sample   (s1_sample_r[g]),
      .invert   (lane_invert[g]),
      .deadzone ((g < 4) ? deadzone_r : DZ_W'(0)),
      .value    (scaled[g])
    );
  end

  always_comb begin
    // D-pad as stick: Left beats Right, Up beats Down.
    if (btn_res.dpad[BTN_LEFT_BIT]) begin
      dpad_x = AXIS_MIN;
    end else if (btn_res.dpad[BTN_RIGHT_BIT]) begin
      dpad_x = AXIS_MAX;
    end else begin
      dpad_x = AXIS_CENTER;
    end
    if (btn_res.dpad[BTN_UP_BIT]) begin
      dpad_y = AXIS_MIN;
    end else if (btn_res.dpad[BTN_DOWN_BIT]) begin
      dpad_y = AXIS_MAX;
    end else begin
      dpad_y = AXIS_CENTER;
    end

    for (int i = 0; i < NUM_AXES; i++) begin
      axis_nxt[i] = axis_r[i];
    end

    // Stick mode drives one stick from the d-pad; leaving it re-centres.
    if (btn_res.mode == MODE_LEFT) begin
      axis_nxt[0] = dpad_x;
      axis_nxt[1] = dpad_y;
    end else if (btn_res.mode != MODE_BUTTONS) begin
      axis_nxt[2] = dpad_x;
      axis_nxt[3] = dpad_y;
    end else if (last_mode_r == MODE_LEFT) begin
      axis_nxt[0] = AXIS_CENTER;
      axis_nxt[1] = AXIS_CENTER;
    end else if (last_mode_r != MODE_BUTTONS) begin
      axis_nxt[2] = AXIS_CENTER;
      axis_nxt[3] = AXIS_CENTER;
    end

    // Wired converter channels override.
    for (int i = 0; i < NUM_AXES; i++) begin
      if (axis_enable_r[i]) begin
        axis_nxt[i] = scaled[i];
      end
    end

    held_nxt = btn_res.buttons;

    // The hat has the last word on the right stick.
    if (hat_enable_r) begin
      if (s1_hat_r[HAT_LEFT_BIT]) begin
        axis_nxt[2] = AXIS_MIN;
      end else if (s1_hat_r[HAT_RIGHT_BIT]) begin
        axis_nxt[2] = AXIS_MAX;
      end else begin
        axis_nxt[2] = AXIS_CENTER;
      end
      if (s1_hat_r[HAT_UP_BIT]) begin
        axis_nxt[3] = AXIS_MIN;
      end else if (s1_hat_r[HAT_DOWN_BIT]) begin
        axis_nxt[3] = AXIS_MAX;
      end else begin
        axis_nxt[3] = AXIS_CENTER;
      end
      if (s1_hat_r != '0) begin
        held_nxt[BTN_R3_BIT] = 1'b0;
      end
    end
  end

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r    <= '0;
      axis_enable_r <= '0;
      axis_invert_r <= '0;
      hat_enable_r  <= 1'b0;
      tog_a_r       <= TOG_NONE;
      tog_b_r       <= TOG_NONE;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_DEADZONE:    deadzone_r    <= cfg_wdata[DZ_W-1:0];
        CFG_AXIS_ENABLE: axis_enable_r <= cfg_wdata[NUM_AXES-1:0];
        CFG_AXIS_INVERT: axis_invert_r <= cfg_wdata[3:0];
        CFG_HAT_ENABLE:  hat_enable_r  <= cfg_wdata[0];
        CFG_TOGGLE_A:    tog_a_r       <= cfg_wdata[1:0];
        CFG_TOGGLE_B:    tog_b_r       <= cfg_wdata[1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_raw_r    <= in_tdata[23:0];
      s1_levels_r <= in_tdata[25:24];
      s1_hat_r    <= in_tdata[29:26];
      for (int i = 0; i < NUM_AXES; i++) begin
        s1_sample_r[i] <= in_tdata[30 + i*SAMPLE_W +: SAMPLE_W];
      end
    end
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      prev_raw_r  <= '0;
      held_r      <= '0;
      combo_r     <= '{was_held: 1'b0, consumed: 1'b0, chosen: MODE_BUTTONS};
      last_mode_r <= MODE_BUTTONS;
      for (int i = 0; i < NUM_AXES; i++) begin
        axis_r[i] <= (i < 4) ? AXIS_CENTER : AXIS_MIN;
      end
    end else begin
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (fire) begin
        prev_raw_r  <= s1_raw_r;
        held_r      <= held_nxt;
        combo_r     <= combo_nxt;
        last_mode_r <= btn_res.mode;
        for (int i = 0; i < NUM_AXES; i++) begin
          axis_r[i] <= axis_nxt[i];
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {axis_r[5], axis_r[4], axis_r[3], axis_r[2],
                       axis_r[1], axis_r[0], held_r};

endmodule

`default_nettype wire
